### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every edge outside reset
`define URS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same cycle implication
`define URS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next cycle implication
`define URS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/urs_pkg.sv
package urs_pkg;

   localparam int ECHO_BITS  = 16;
   localparam int ECHO_EXT_W = 24;
   localparam int FIELD_W    = 16;
   localparam int CONV_SHIFT = 16;
   localparam int PROD_W     = ECHO_BITS + 15;
   localparam int CONV_W     = PROD_W - CONV_SHIFT;
   localparam logic [14:0] CONV_MUL = 15'd18017;

   localparam int DIST_W = 11;
   localparam int SUM_W  = 13;
   localparam logic [DIST_W-1:0] DIST_MIN_Q4  = 11'd32;
   localparam logic [DIST_W-1:0] DIST_CAP_Q4  = 11'd1280;
   localparam logic [DIST_W-1:0] DIST_HIGH_Q4 = 11'd1360;

   // floor(x / 3) as (x * 2731) >> 13, exact for x below 8192
   localparam logic [11:0] DIV3_MUL   = 12'd2731;
   localparam int          DIV3_SHIFT = 13;
   localparam int          DIV3_PROD_W = SUM_W + 12;

   localparam int OBS_W = 7;
   localparam logic [OBS_W-1:0] OBS_OFFSET_CM = 7'd10;
   localparam logic signed [7:0] STEER_HI = 8'sd3;
   localparam logic signed [7:0] STEER_LO = -8'sd3;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_LOW = 2'd1;

   localparam logic [DIST_W-1:0] RISE_LIMIT_RESET = 11'd32;
   localparam logic [OBS_W-1:0]  OBSTACLE_RESET   = 7'd30;

   typedef struct packed {
      logic conv_en;
      logic upd_en;
   } lane_ctrl_type;

   function automatic logic [DIST_W-1:0] min_dist(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
      min_dist = (a < b) ? a : b;
   endfunction

endpackage

### src/urs_lane.sv
`include "assert_macros.svh"

module urs_lane
   import urs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lane_ctrl_type         ctrl,
   input  logic [FIELD_W-1:0]    echo_us,
   input  logic [DIST_W-1:0]     rise_limit_q4,
   output logic [DIST_W-1:0]     avg_q4
);

   logic [ECHO_EXT_W-1:0] echo_ext;
   logic [PROD_W-1:0]     prod;
   logic [CONV_W-1:0]     conv_ff, conv_in;

   logic [DIST_W-1:0] h0_ff, h1_ff, h2_ff, avg_ff;
   logic [DIST_W-1:0] h2_in, avg_in;
   logic [DIST_W-1:0] dist_q4;
   logic signed [DIST_W+1:0] diff;
   logic [DIST_W:0]   lim_sum;
   logic              limit_hit;
   logic [SUM_W-1:0]  sum;
   logic [DIV3_PROD_W-1:0] div_prod;

   // duration to Q4 cm
   assign echo_ext = ECHO_EXT_W'(echo_us);
   assign prod     = PROD_W'(echo_ext[ECHO_BITS-1:0]) * PROD_W'(CONV_MUL);
   assign conv_in  = prod[PROD_W-1:CONV_SHIFT];

   always_ff @(posedge clock) begin
      if (ctrl.conv_en) begin
         conv_ff <= conv_in;
      end
   end

   // clamp
   always_comb begin
      priority if (conv_ff < CONV_W'(DIST_MIN_Q4)) begin
         dist_q4 = DIST_MIN_Q4;
      end else if (conv_ff > CONV_W'(DIST_CAP_Q4)) begin
         dist_q4 = DIST_HIGH_Q4;
      end else begin
         dist_q4 = conv_ff[DIST_W-1:0];
      end
   end

   // rise limit against the last average
   assign diff      = $signed({2'b00, dist_q4}) - $signed({2'b00, avg_ff});
   assign limit_hit = (dist_q4 > h2_ff) && (diff > $signed({2'b00, rise_limit_q4}));
   assign lim_sum   = {1'b0, avg_ff} + {1'b0, rise_limit_q4};
   assign h2_in     = limit_hit ? lim_sum[DIST_W-1:0] : dist_q4;

   // three tap average
   assign sum      = SUM_W'(h1_ff) + SUM_W'(h2_ff) + SUM_W'(h2_in);
   assign div_prod = DIV3_PROD_W'(sum) * DIV3_PROD_W'(DIV3_MUL);
   assign avg_in   = div_prod[DIV3_SHIFT+DIST_W-1:DIV3_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_ff  <= '0;
         h1_ff  <= '0;
         h2_ff  <= '0;
         avg_ff <= '0;
      end else if (ctrl.upd_en) begin
         h0_ff  <= h1_ff;
         h1_ff  <= h2_ff;
         h2_ff  <= h2_in;
         avg_ff <= avg_in;
      end
   end

   assign avg_q4 = avg_ff;

   `URS_ASSERT(a_newest_in_range, clock, reset, h2_ff <= DIST_HIGH_Q4, "stored distance out of range")
   `URS_ASSERT_NEXT(a_avg_in_range, clock, reset, ctrl.upd_en, avg_ff <= DIST_HIGH_Q4, "lane average out of range")

endmodule

### src/urs_merge.sv
module urs_merge
   import urs_pkg::*;
(
   input  logic                    clock,
   input  logic                    load,
   input  logic [DIST_W-1:0]       front_q4,
   input  logic [DIST_W-1:0]       right_q4,
   input  logic [DIST_W-1:0]       left_q4,
   input  logic signed [7:0]       steer_command,
   input  logic [OBS_W-1:0]        obstacle_low_cm,
   output logic [DIST_W-1:0]       front_avg_q4,
   output logic [DIST_W-1:0]       right_avg_q4,
   output logic [DIST_W-1:0]       left_avg_q4,
   output logic [DIST_W-1:0]       fused_distance_q4
);

   logic [DIST_W-1:0] front_ff, right_ff, left_ff, fused_ff, fused_in;
   logic [OBS_W-1:0]  obs_off;
   logic [DIST_W-1:0] thr_q4;
   logic              thr_valid;
   logic [DIST_W-1:0] pair;

   assign obs_off   = obstacle_low_cm - OBS_OFFSET_CM;
   assign thr_valid = obstacle_low_cm >= OBS_OFFSET_CM;
   assign thr_q4    = {obs_off, 4'b0000};

   always_comb begin
      pair     = '0;
      fused_in = '0;
      priority if (steer_command > STEER_HI) begin
         pair     = min_dist(front_q4, left_q4);
         fused_in = (thr_valid && right_q4 <= thr_q4) ? min_dist(pair, right_q4) : pair;
      end else if (steer_command < STEER_LO) begin
         pair     = min_dist(front_q4, right_q4);
         fused_in = (thr_valid && left_q4 <= thr_q4) ? min_dist(pair, left_q4) : pair;
      end else begin
         pair     = min_dist(left_q4, right_q4);
         fused_in = min_dist(pair, front_q4);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_q4;
         right_ff <= right_q4;
         left_ff  <= left_q4;
         fused_ff <= fused_in;
      end
   end

   assign front_avg_q4      = front_ff;
   assign right_avg_q4      = right_ff;
   assign left_avg_q4       = left_ff;
   assign fused_distance_q4 = fused_ff;

endmodule

### src/ultrasonic_range_smoother_fusion.sv
// Three ultrasonic ranges (front, right, left) are converted to cm in Q4, clamped,
// rise limited and averaged over three samples in parallel lanes, then fused into a
// steering-selected minimum. One request can be taken every cycle unless the response
// side stalls; each result passes the duration multiply, lane filter update and merge
// registers in that order. The lane filter state closes in one register update per
// request, which sets the one-per-cycle throughput. csr writes are always accepted
// and should be made while no request is in flight.
`include "assert_macros.svh"

module ultrasonic_range_smoother_fusion
   import urs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // front_echo_us, right_echo_us, left_echo_us, steer_command
   input  logic [55:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // front_avg_q4, right_avg_q4, left_avg_q4, fused_distance_q4, zero pad
   output logic [47:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_data
);

   logic [DIST_W-1:0] rise_limit_ff;
   logic [OBS_W-1:0]  obstacle_ff;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   lane_ctrl_type ctrl;
   logic out_en;

   logic signed [7:0] steer1_ff, steer2_ff;
   logic [DIST_W-1:0] front_q4, right_q4, left_q4;
   logic [DIST_W-1:0] front_o, right_o, left_o, fused_o;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_limit_ff <= RISE_LIMIT_RESET;
         obstacle_ff   <= OBSTACLE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RISE_LIMIT:   rise_limit_ff <= csr_data;
            CSR_OBSTACLE_LOW: obstacle_ff   <= csr_data[OBS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow
   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign ctrl.conv_en = req_tvalid && rdy1;
   assign ctrl.upd_en  = v1_ff && rdy2;
   assign out_en       = v2_ff && rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_tvalid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.conv_en) begin
         steer1_ff <= $signed(req_tdata[55:48]);
      end
      if (ctrl.upd_en) begin
         steer2_ff <= steer1_ff;
      end
   end

   urs_lane u_lane_front (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .echo_us       (req_tdata[15:0]),
      .rise_limit_q4 (rise_limit_ff),
      .avg_q4        (front_q4)
   );

   urs_lane u_lane_right (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .echo_us       (req_tdata[31:16]),
      .rise_limit_q4 (rise_limit_ff),
      .avg_q4        (right_q4)
   );

   urs_lane u_lane_left (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .echo_us       (req_tdata[47:32]),
      .rise_limit_q4 (rise_limit_ff),
      .avg_q4        (left_q4)
   );

   urs_merge u_merge (
      .clock             (clock),
      .load              (out_en),
      .front_q4          (front_q4),
      .right_q4          (right_q4),
      .left_q4           (left_q4),
      .steer_command     (steer2_ff),
      .obstacle_low_cm   (obstacle_ff),
      .front_avg_q4      (front_o),
      .right_avg_q4      (right_o),
      .left_avg_q4       (left_o),
      .fused_distance_q4 (fused_o)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {4'b0000, fused_o, left_o, right_o, front_o};

   `URS_ASSERT_IMPL(a_fused_le_front, clock, reset, rsp_tvalid, fused_o <= front_o, "fused distance above front lane")
   `URS_ASSERT_NEXT(a_stage_kept, clock, reset, ctrl.upd_en && !out_en, v2_ff, "lane result dropped")

endmodule

### dv/range_fusion_checker.sv
`timescale 1ns / 100ps

module range_fusion_checker
   import urs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [55:0]          req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [47:0]          rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_data,
   output int                   mismatch_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [DIST_W-1:0] fused;
      logic [DIST_W-1:0] left;
      logic [DIST_W-1:0] right;
      logic [DIST_W-1:0] front;
   } range_set_type;

   logic [DIST_W-1:0] rise_limit;
   logic [OBS_W-1:0]  obstacle_cm;
   logic [DIST_W-1:0] lane_hist [3][3];
   logic [DIST_W-1:0] lane_avg [3];
   range_set_type     expected_ranges [$];
   int                error_total;

   assign mismatch_count = error_total;
   assign pending_count  = expected_ranges.size();

   function automatic logic [DIST_W-1:0] smaller_of(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // one filter update of a lane: convert, clamp, limit the rise, average three
   function automatic logic [DIST_W-1:0] lane_step(int lane, logic [15:0] echo);
      logic [31:0]       conv;
      int                dist_q4;
      int                avg;
      int                lim;
      logic [DIST_W-1:0] stored;
      conv = (32'(echo) * 32'(CONV_MUL)) >> CONV_SHIFT;
      if (conv < DIST_MIN_Q4)
         dist_q4 = DIST_MIN_Q4;
      else if (conv > DIST_CAP_Q4)
         dist_q4 = DIST_HIGH_Q4;
      else
         dist_q4 = int'(conv);
      avg = int'(lane_avg[lane]);
      lim = int'(rise_limit);
      if (dist_q4 > int'(lane_hist[lane][2]) && (dist_q4 - avg) > lim)
         stored = DIST_W'(avg + lim);
      else
         stored = DIST_W'(dist_q4);
      lane_hist[lane][0] = lane_hist[lane][1];
      lane_hist[lane][1] = lane_hist[lane][2];
      lane_hist[lane][2] = stored;
      lane_avg[lane] = DIST_W'((int'(lane_hist[lane][0]) + int'(lane_hist[lane][1])
                                + int'(lane_hist[lane][2])) / 3);
      return lane_avg[lane];
   endfunction

   function automatic range_set_type predict_ranges(logic [55:0] request);
      range_set_type     res;
      logic signed [7:0] steer;
      int                thr;
      res.front = lane_step(0, request[15:0]);
      res.right = lane_step(1, request[31:16]);
      res.left  = lane_step(2, request[47:32]);
      steer = request[55:48];
      thr = (int'(obstacle_cm) - int'(OBS_OFFSET_CM)) * 16;
      if (steer > STEER_HI) begin
         res.fused = smaller_of(res.front, res.left);
         if (int'(res.right) <= thr)
            res.fused = smaller_of(res.fused, res.right);
      end else if (steer < STEER_LO) begin
         res.fused = smaller_of(res.front, res.right);
         if (int'(res.left) <= thr)
            res.fused = smaller_of(res.fused, res.left);
      end else begin
         res.fused = smaller_of(smaller_of(res.left, res.right), res.front);
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [DIST_W-1:0] exp_v,
                                       logic [DIST_W-1:0] got_v);
      if (got_v !== exp_v) begin
         error_total++;
         if (error_total <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endfunction

   initial error_total = 0;

   always @(posedge clock) begin
      range_set_type exp_r;
      range_set_type got_r;
      if (reset) begin
         rise_limit  = RISE_LIMIT_RESET;
         obstacle_cm = OBSTACLE_RESET;
         for (int i = 0; i < 3; i++) begin
            lane_avg[i] = '0;
            for (int j = 0; j < 3; j++)
               lane_hist[i][j] = '0;
         end
         expected_ranges.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RISE_LIMIT)
               rise_limit = csr_data;
            else if (csr_index == CSR_OBSTACLE_LOW)
               obstacle_cm = csr_data[OBS_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got_r = {rsp_tdata[43:33], rsp_tdata[32:22], rsp_tdata[21:11], rsp_tdata[10:0]};
            if (expected_ranges.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: unexpected response %h", $time, rsp_tdata);
            end else begin
               exp_r = expected_ranges.pop_front();
               check_field("front_avg", exp_r.front, got_r.front);
               check_field("right_avg", exp_r.right, got_r.right);
               check_field("left_avg", exp_r.left, got_r.left);
               check_field("fused_distance", exp_r.fused, got_r.fused);
               if (rsp_tdata[47:44] !== 4'b0) begin
                  error_total++;
                  if (error_total <= 10)
                     $display("%0t: pad bits not zero, got %h", $time, rsp_tdata[47:44]);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_ranges.push_back(predict_ranges(req_tdata));
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import urs_pkg::*;

   localparam int RANGE_TIMEOUT  = 2000;
   localparam int PHASES         = 12;
   localparam int PHASE_REQUESTS = 136;
   localparam int DRAIN_CYCLES   = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_OBSTACLE_LOW + 2'd1;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [55:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIST_W-1:0]    csr_data;

   int          mismatch_count;
   int          pending_count;
   int          stall_cycles;
   bit          send_idle_on;
   bit          recv_idle_on;
   logic [15:0] last_echo [3];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   ultrasonic_range_smoother_fusion dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   range_fusion_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   function automatic logic [55:0] pack_request(logic [15:0] f, logic [15:0] r,
                                                logic [15:0] l, logic [7:0] steer);
      return {steer, l, r, f};
   endfunction

   // mostly slowly moving echoes, with jumps, full-range noise and clamp edges
   function automatic logic [15:0] next_echo(logic [15:0] prev);
      int pick;
      int delta;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         delta = $urandom_range(0, 400);
         v = int'(prev) + delta - 200;
         if (v < 0)
            v = 0;
         if (v > 65535)
            v = 65535;
      end else if (pick < 70) begin
         v = $urandom_range(117, 4700);
      end else if (pick < 85) begin
         v = $urandom_range(0, 65535);
      end else begin
         case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 116;
            2: v = 117;
            3: v = 4657;
            4: v = 4661;
            default: v = 65535;
         endcase
      end
      return 16'(v);
   endfunction

   task automatic send_request(logic [55:0] request);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= request;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DIST_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // response side back-pressure
   initial begin
      int wait_n;
      rsp_tready = 1'b0;
      forever begin
         wait_n = recv_idle_on ? $urandom_range(0, 5) : 0;
         repeat (wait_n) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= RANGE_TIMEOUT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [55:0]       directed [$];
      logic [DIST_W-1:0] rise_v;
      logic [OBS_W-1:0]  obs_v;
      logic [7:0]        steer;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_RISE_LIMIT;
      csr_data     = '0;
      stall_cycles = 0;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      foreach (last_echo[i])
         last_echo[i] = 16'd1000;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // clamp edges, steering regions and rise limiting at reset settings
      directed.push_back(pack_request(16'd0, 16'd0, 16'd0, 8'sd0));
      directed.push_back(pack_request(16'd65535, 16'd65535, 16'd65535, 8'sd127));
      directed.push_back(pack_request(16'd116, 16'd117, 16'd4657, -8'sd128));
      directed.push_back(pack_request(16'd4661, 16'd4660, 16'd65535, 8'sd4));
      directed.push_back(pack_request(16'd4000, 16'd100, 16'd2000, -8'sd4));
      directed.push_back(pack_request(16'd3000, 16'd3000, 16'd3000, 8'sd3));
      directed.push_back(pack_request(16'd200, 16'd4000, 16'd4000, -8'sd3));
      directed.push_back(pack_request(16'd65535, 16'd0, 16'd200, 8'sd5));
      directed.push_back(pack_request(16'd0, 16'd65535, 16'd0, -8'sd5));
      directed.push_back(pack_request(16'd1000, 16'd1000, 16'd1000, 8'sd0));
      directed.push_back(pack_request(16'd1000, 16'd1000, 16'd1000, 8'sd0));
      directed.push_back(pack_request(16'd1000, 16'd1000, 16'd1000, 8'sd0));
      directed.push_back(pack_request(16'd4600, 16'd1000, 16'd4600, 8'sd10));
      directed.push_back(pack_request(16'd4600, 16'd4600, 16'd1000, -8'sd10));
      directed.push_back(pack_request(16'd4600, 16'd4600, 16'd4600, 8'sd1));
      directed.push_back(pack_request(16'd300, 16'd120, 16'd4600, -8'sd1));
      directed.push_back(pack_request(16'd300, 16'd120, 16'd4600, 8'sd100));
      directed.push_back(pack_request(16'hAAAA, 16'h5555, 16'hAAAA, 8'h55));
      directed.push_back(pack_request(16'h5555, 16'hAAAA, 16'h5555, 8'hAA));
      directed.push_back(pack_request(16'd150, 16'd150, 16'd150, -8'sd100));
      foreach (directed[i])
         send_request(directed[i]);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin rise_v = 11'd0;    obs_v = 7'd10;  end
            1: begin rise_v = 11'd1360; obs_v = 7'd85;  end
            2: begin rise_v = 11'd2047; obs_v = 7'd127; end
            3: begin rise_v = 11'd1;    obs_v = 7'd0;   end
            4: begin rise_v = 11'd16;   obs_v = 7'd9;   end
            default: begin
               rise_v = $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($urandom_range(0, 400));
               obs_v  = 7'($urandom);
            end
         endcase
         // upper data bits are don't-care for the obstacle register
         if (p % 2 == 0) begin
            write_csr(CSR_RISE_LIMIT, rise_v);
            write_csr(CSR_OBSTACLE_LOW, {4'($urandom), obs_v});
         end else begin
            write_csr(CSR_OBSTACLE_LOW, {4'($urandom), obs_v});
            write_csr(CSR_RISE_LIMIT, rise_v);
         end
         if (p % 3 == 0)
            write_csr(CSR_SPARE + CSR_IDX_W'($urandom_range(0, 1)), 11'($urandom));
         send_idle_on = (p % 4 == 1) || (p % 4 == 3);
         recv_idle_on = (p % 4 == 2) || (p % 4 == 3);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            foreach (last_echo[i])
               last_echo[i] = next_echo(last_echo[i]);
            if ($urandom_range(0, 1))
               steer = 8'($urandom);
            else
               steer = 8'(int'($urandom_range(0, 10)) - 5);
            send_request(pack_request(last_echo[0], last_echo[1], last_echo[2], steer));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
